// ----- rtl/core/lfps_pkg.sv -----
// Package of the line follow PID steering core: beat types, codes, constants and weights.
`default_nettype none

package lfps_pkg;

	// Widths fixed by the beat formats.
	localparam int unsigned SENSOR_W = 8;
	localparam int unsigned WSUM_W   = 9;
	localparam int unsigned MAG_W    = 8;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned ERR_W    = 8;
	localparam int unsigned DIFF_W   = 9;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned ACC_W    = 34;
	localparam int unsigned PROD_W   = 32;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_END_THRESHOLD  = 3'd4;

	// Output saturation bounds.
	localparam logic signed [ACC_W-1:0] PID_MAX = 34'sd32767;
	localparam logic signed [ACC_W-1:0] PID_MIN = -34'sd32768;

	// Signed weight of each sensor, leftmost first.
	localparam logic signed [WSUM_W-1:0] WEIGHTS [SENSOR_W] = '{
		-9'sd80, -9'sd50, -9'sd15, -9'sd2, 9'sd2, 9'sd15, 9'sd50, 9'sd80
	};

	typedef struct packed {
		logic [7:0]         sensor_bits;
		logic               ramp_req;
		logic               restart;
		logic signed [31:0] start_yaw;
		logic               clear_end;
	} lfps_in_t;

	typedef struct packed {
		logic signed [31:0] yaw_cmd;
		logic signed [15:0] pid_out;
		logic               reached_end;
		logic               no_line;
		logic               ramp_request;
	} lfps_out_t;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [CNT_W-1:0] den;
	} lfps_div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ERR_W-1:0] quot;
	} lfps_div_rsp_t;

	// Multiply-accumulate request.
	typedef struct packed {
		logic                     clear;
		logic                     en;
		logic signed [GAIN_W-1:0] a;
		logic signed [GAIN_W-1:0] b;
	} lfps_mac_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SUM,
		S_MP,
		S_MI,
		S_MD,
		S_DRAIN,
		S_FIN
	} lfps_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lfps_div.sv -----
// Restoring divider of the sensor weight sum by the active count, one quotient bit a cycle.
`default_nettype none

module lfps_div
	import lfps_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lfps_div_req_t req,
	output lfps_div_rsp_t      rsp
);

	localparam int unsigned STEP_W = $clog2(MAG_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [MAG_W-1:0]  quo_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;

	logic [CNT_W:0]    shifted;
	logic              fits;

	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.mag;
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(shifted - {1'b0, den_q}) : shifted[CNT_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	// The quotient never exceeds the largest weight, so it fits the error width.
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// ----- rtl/core/lfps_mac.sv -----
// Shared multiply-accumulate unit with a registered product.
`default_nettype none

module lfps_mac
	import lfps_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lfps_mac_req_t        req,
	output logic signed [ACC_W-1:0]   acc
);

	logic                     prod_vld_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			acc_q       <= '0;
		end else begin
			prod_vld_s1 <= req.en;
			if (req.clear) begin
				acc_q <= '0;
			end else if (prod_vld_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_s1 <= req.a * req.b;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/line_follow_pid_steer_core.sv -----
// Top level of the line follow PID steering core: sequencer, state and beat registers.
`default_nettype none

// Channel  Direction  Handshake            Payload
// frame    in         frame_valid/stall    lfps_in_t  (sensor bits, restart, start yaw)
// steer    out        steer_valid/stall    lfps_out_t (yaw command, PID output, flags)
// cfg      in         cfg_valid/ready      cfg_index, cfg_data
//
// A frame with at least one active sensor goes from acceptance through the
// bit-serial divider, the integral clamp, the shared multiplier and the finish
// step back to the idle state, which takes the next frame. A frame with no
// active sensor skips the divider and goes straight to the integral clamp.
// Reset clears all loop state and loads the register defaults; no sweep follows.
// A result waits in the steer register while the next frame is already worked on;
// only the finish step waits when that register is still full and stalled.

module line_follow_pid_steer_core
	import lfps_pkg::*;
#(
	parameter int unsigned SENSOR_COUNT = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  frame_valid,
	output logic                       frame_stall,
	input  wire lfps_in_t              frame,

	output logic                       steer_valid,
	input  wire logic                  steer_stall,
	output lfps_out_t                  steer,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Only the first eight sensors carry a weight.
	localparam int unsigned USED_SENSORS = (SENSOR_COUNT < SENSOR_W) ? SENSOR_COUNT : SENSOR_W;

	// Configuration registers.
	logic signed [GAIN_W-1:0] gain_p_q;
	logic signed [GAIN_W-1:0] gain_i_q;
	logic signed [GAIN_W-1:0] gain_d_q;
	logic [14:0]              integral_limit_q;
	logic [CNT_W-1:0]         end_threshold_q;

	// Loop state.
	logic signed [15:0]       error_sum_q;
	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [31:0]       yaw_target_q;
	logic                     end_seen_q;

	// Per-frame working registers.
	lfps_state_t              state_q, state_d;
	logic signed [ERR_W-1:0]  err_q;
	logic                     none_q;
	logic                     ramp_q;

	// Result register.
	logic                     steer_valid_q;
	lfps_out_t                steer_q;

	logic                     frame_acc;
	logic                     out_load;
	logic signed [WSUM_W-1:0] wsum;
	logic [CNT_W-1:0]         cnt;
	logic [WSUM_W-1:0]        wsum_abs;
	logic signed [ERR_W-1:0]  last_error_eff;

	logic signed [16:0]       sum_raw;
	logic signed [16:0]       limit_pos;
	logic signed [15:0]       sum_clamped;
	logic signed [DIFF_W-1:0] diff;
	logic signed [ACC_W-1:0]  acc;
	logic signed [15:0]       pid_sat;

	lfps_div_req_t            div_req;
	lfps_div_rsp_t            div_rsp;
	lfps_mac_req_t            mac_req;

	assign cfg_ready   = 1'b1;
	assign frame_stall = (state_q != S_IDLE);
	assign frame_acc   = frame_valid && !frame_stall;

	// Weighted sum and count of the active sensors in this frame.
	always_comb begin
		wsum = '0;
		cnt  = '0;
		for (int i = 0; i < SENSOR_W; i++) begin
			if ((i < USED_SENSORS) && frame.sensor_bits[i]) begin
				wsum = wsum + WEIGHTS[i];
				cnt  = cnt + 1'b1;
			end
		end
	end

	assign wsum_abs       = wsum[WSUM_W-1] ? WSUM_W'(-wsum) : wsum;
	assign last_error_eff = frame.restart ? '0 : last_error_q;

	// Integral update, clamped to the symmetric limit.
	assign limit_pos = $signed({2'b00, integral_limit_q});
	assign sum_raw   = 17'(error_sum_q) + 17'(err_q);

	always_comb begin
		if (sum_raw > limit_pos) begin
			sum_clamped = limit_pos[15:0];
		end else if (sum_raw < -limit_pos) begin
			sum_clamped = 16'(-limit_pos);
		end else begin
			sum_clamped = sum_raw[15:0];
		end
	end

	assign diff = DIFF_W'(err_q) - DIFF_W'(last_error_q);

	// Output saturation to 16-bit signed.
	always_comb begin
		if (acc > PID_MAX) begin
			pid_sat = PID_MAX[15:0];
		end else if (acc < PID_MIN) begin
			pid_sat = PID_MIN[15:0];
		end else begin
			pid_sat = acc[15:0];
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (frame_acc) begin
					state_d = (cnt == '0) ? S_SUM : S_DIV;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_SUM;
				end
			end
			S_SUM:   state_d = S_MP;
			S_MP:    state_d = S_MI;
			S_MI:    state_d = S_MD;
			S_MD:    state_d = S_DRAIN;
			S_DRAIN: state_d = S_FIN;
			S_FIN: begin
				if (!steer_valid_q || !steer_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: divider start, multiplier operands, result load.
	always_comb begin
		div_req.start = 1'b0;
		div_req.neg   = wsum[WSUM_W-1];
		div_req.mag   = wsum_abs[MAG_W-1:0];
		div_req.den   = cnt;
		mac_req.clear = 1'b0;
		mac_req.en    = 1'b0;
		mac_req.a     = gain_p_q;
		mac_req.b     = GAIN_W'(err_q);
		out_load      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				div_req.start = frame_acc && (cnt != '0);
			end
			S_MP: begin
				mac_req.clear = 1'b1;
				mac_req.en    = 1'b1;
			end
			S_MI: begin
				mac_req.en = 1'b1;
				mac_req.a  = gain_i_q;
				mac_req.b  = error_sum_q;
			end
			S_MD: begin
				mac_req.en = 1'b1;
				mac_req.a  = gain_d_q;
				mac_req.b  = GAIN_W'(diff);
			end
			S_FIN: begin
				out_load = !steer_valid_q || !steer_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= 16'sd8;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= 15'd10000;
			end_threshold_q  <= 4'd7;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GAIN_P:         gain_p_q         <= cfg_data;
				CFG_GAIN_I:         gain_i_q         <= cfg_data;
				CFG_GAIN_D:         gain_d_q         <= cfg_data;
				CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[14:0];
				CFG_END_THRESHOLD:  end_threshold_q  <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Loop state. Clear-end and restart take effect as the frame is taken, and the
	// end flag then picks up this frame's count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
			yaw_target_q <= '0;
			end_seen_q   <= 1'b0;
		end else begin
			if (frame_acc) begin
				end_seen_q <= (cnt >= end_threshold_q) ||
				              (end_seen_q && !frame.restart && !frame.clear_end);
				if (frame.restart) begin
					yaw_target_q <= frame.start_yaw;
					error_sum_q  <= '0;
					last_error_q <= '0;
				end
			end
			if (state_q == S_SUM) begin
				error_sum_q <= sum_clamped;
			end
			if (out_load) begin
				last_error_q <= err_q;
				yaw_target_q <= yaw_target_q + 32'(pid_sat);
			end
		end
	end

	// Frame working registers. With no active sensor the error repeats, or is zero on a restart.
	always_ff @(posedge clk) begin
		if (frame_acc) begin
			none_q <= (cnt == '0);
			ramp_q <= frame.ramp_req;
			err_q  <= last_error_eff;
		end else if (state_q == S_DIV && div_rsp.done) begin
			err_q <= div_rsp.quot;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_valid_q <= 1'b0;
		end else if (out_load) begin
			steer_valid_q <= 1'b1;
		end else if (!steer_stall) begin
			steer_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			steer_q.yaw_cmd      <= yaw_target_q + 32'(pid_sat);
			steer_q.pid_out      <= pid_sat;
			steer_q.reached_end  <= end_seen_q;
			steer_q.no_line      <= none_q;
			steer_q.ramp_request <= ramp_q;
		end
	end

	assign steer_valid = steer_valid_q;
	assign steer       = steer_q;

	lfps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lfps_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.acc    (acc)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_line_follow_pid_steer_core.sv -----
// Self-checking testbench of the line follow PID steering core: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_line_follow_pid_steer_core
	import lfps_pkg::*;
();

	// The run is cut off here if the block hangs. The slowest legal run is about
	// 900 frames, plus the longest sender gaps and receiver stalls on every beat
	// and one long hold-off, well within this limit.
	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 40;

	// An index past the last register. Writes to it must leave every register alone.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

	// Sensor weights, leftmost sensor first.
	localparam int LINE_WEIGHT [8] = '{-80, -50, -15, -2, 2, 15, 50, 80};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic frame_valid = 1'b0;
	logic frame_stall;
	lfps_in_t frame = '0;

	logic steer_valid;
	logic steer_stall = 1'b0;
	lfps_out_t steer;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	line_follow_pid_steer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame),
		.steer_valid(steer_valid),
		.steer_stall(steer_stall),
		.steer(steer),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the register file. It only changes on an accepted config
	// write, and writes only happen while the core is idle.
	logic signed [15:0] gain_p = 16'sd8;
	logic signed [15:0] gain_i = 16'sd0;
	logic signed [15:0] gain_d = 16'sd0;
	logic [14:0] integral_limit = 15'd10000;
	logic [3:0] end_threshold = 4'd7;

	// Shadow copy of the loop state, advanced once per accepted frame beat.
	int error_sum = 0;
	int last_error = 0;
	logic [31:0] yaw_target = '0;
	bit end_seen = 1'b0;

	// Steering beats that are predicted but have not come out yet, oldest first.
	lfps_out_t pending_steer [$];

	int mismatches = 0;
	int cycle_count = 0;

	// Idling knobs. The sender leaves a gap after a beat with gap_pct percent
	// chance; the receiver starts a stall run with stall_pct percent chance.
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	// Length of one idle stretch, drawn from three ranges: mostly the shortest, now and then the longest.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Works out the steering beat for one frame and advances the shadow state.
	// Order within a frame: the end flag clear, then restart, then the frame itself.
	function automatic lfps_out_t steer_from_frame(input lfps_in_t f);
		lfps_out_t r;
		int wsum;
		int hits;
		int err;
		int sum;
		int i;
		longint pid;
		bit dark;
		wsum = 0;
		hits = 0;
		if (f.clear_end)
			end_seen = 1'b0;
		if (f.restart) begin
			yaw_target = f.start_yaw;
			error_sum = 0;
			last_error = 0;
			end_seen = 1'b0;
		end
		for (i = 0; i < 8; i++) begin
			if (f.sensor_bits[i]) begin
				wsum += LINE_WEIGHT[i];
				hits++;
			end
		end
		if (hits >= int'(end_threshold))
			end_seen = 1'b1;
		// With the line lost the last position is held, so the D term drops out.
		dark = (hits == 0);
		err = dark ? last_error : wsum / hits;
		sum = error_sum + err;
		if (sum > int'(integral_limit))
			sum = int'(integral_limit);
		if (sum < -int'(integral_limit))
			sum = -int'(integral_limit);
		error_sum = sum;
		pid = longint'(gain_p) * err + longint'(gain_i) * sum
			+ longint'(gain_d) * (err - last_error);
		if (pid > 32767)
			pid = 32767;
		if (pid < -32768)
			pid = -32768;
		last_error = err;
		yaw_target = yaw_target + pid[31:0];
		r.yaw_cmd = yaw_target;
		r.pid_out = pid[15:0];
		r.reached_end = end_seen;
		r.no_line = dark;
		r.ramp_request = f.ramp_req;
		return r;
	endfunction

	function automatic lfps_in_t make_frame(input logic [7:0] bits, input bit ramp,
			input bit rst, input logic [31:0] yaw, input bit clr);
		lfps_in_t f;
		f.sensor_bits = bits;
		f.ramp_req = ramp;
		f.restart = rst;
		f.start_yaw = yaw;
		f.clear_end = clr;
		return f;
	endfunction

	// Random frame. Most are a plausible line under the bar (one to three adjacent
	// sensors); the rest are lost line, full bar, forks and plain noise.
	function automatic lfps_in_t random_frame();
		lfps_in_t f;
		int roll;
		int w;
		logic [7:0] bits;
		roll = $urandom_range(0, 99);
		w = $urandom_range(1, 3);
		if (roll < 60)
			bits = 8'((1 << w) - 1) << $urandom_range(0, 8 - w);
		else if (roll < 70)
			bits = 8'h00;
		else if (roll < 75)
			bits = 8'hFF;
		else if (roll < 82)
			bits = (8'h01 << $urandom_range(0, 3)) | (8'h10 << $urandom_range(0, 3));
		else
			bits = 8'($urandom_range(0, 255));
		f = make_frame(bits, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 4,
			$urandom(), $urandom_range(0, 99) < 8);
		return f;
	endfunction

	function automatic logic [15:0] random_gain();
		int g;
		case ($urandom_range(0, 3))
			0: g = $urandom_range(0, 32) - 16;
			1: g = $urandom_range(0, 512) - 256;
			2: g = $urandom();
			default: g = $urandom_range(0, 1) ? 32767 : -32768;
		endcase
		return g[15:0];
	endfunction

	function automatic void field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t steer %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	function automatic void check_steer(input lfps_out_t got);
		lfps_out_t want;
		if (pending_steer.size() == 0) begin
			mismatches++;
			$display("%0t steer beat with nothing expected: expected none, actual %h",
				$time, got);
			return;
		end
		want = pending_steer.pop_front();
		field_check("yaw_cmd", want.yaw_cmd, got.yaw_cmd);
		field_check("pid_out", 32'(want.pid_out), 32'(got.pid_out));
		field_check("reached_end", 32'(want.reached_end), 32'(got.reached_end));
		field_check("no_line", 32'(want.no_line), 32'(got.no_line));
		field_check("ramp_request", 32'(want.ramp_request), 32'(got.ramp_request));
	endfunction

	// Receiver. Checks each accepted steering beat, then picks the stall for the
	// next edge. A requested hold-off is counted down here, cycle by cycle.
	always @(posedge clk) begin
		if (arst_n && steer_valid && !steer_stall)
			check_steer(steer);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			steer_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			steer_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = idle_len() - 1;
			steer_stall <= 1'b1;
		end else begin
			steer_stall <= 1'b0;
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("line_follow_pid_steer_core regression: fail");
		$finish;
	end

	// Offers one frame beat and holds it until it is taken, then predicts its
	// result. Valid stays high when no gap follows, so back-to-back beats never
	// see valid dropped and raised in the same step.
	task automatic send_frame(input lfps_in_t f);
		int gap;
		frame <= f;
		frame_valid <= 1'b1;
		@(posedge clk);
		while (frame_stall)
			@(posedge clk);
		pending_steer.push_back(steer_from_frame(f));
		gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering frames and waits until every predicted beat has come out,
	// so the core is idle and registers may be written.
	task automatic drain_steer();
		frame_valid <= 1'b0;
		while (pending_steer.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write. Valid is left high; the caller drops it after its last write.
	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_GAIN_P: gain_p = data;
			CFG_GAIN_I: gain_i = data;
			CFG_GAIN_D: gain_d = data;
			CFG_INTEGRAL_LIMIT: integral_limit = data[14:0];
			CFG_END_THRESHOLD: end_threshold = data[3:0];
			default: ;
		endcase
	endtask

	// Writes all five registers. The limit and threshold words may carry stray
	// upper bits, which the core must drop.
	task automatic set_config(input logic [15:0] p, input logic [15:0] i,
			input logic [15:0] d, input logic [15:0] lim, input logic [15:0] thr);
		cfg_put(CFG_GAIN_P, p);
		cfg_put(CFG_GAIN_I, i);
		cfg_put(CFG_GAIN_D, d);
		cfg_put(CFG_INTEGRAL_LIMIT, lim);
		cfg_put(CFG_END_THRESHOLD, thr);
		cfg_valid <= 1'b0;
	endtask

	// Reset defaults and the corner cases of the position math: line lost from
	// the start, every single sensor, truncation toward zero on both sides,
	// line lost after a position, and yaw wrap in both directions on restart.
	task automatic test_directed_cases();
		int i;
		gap_pct = 30;
		stall_pct = 30;
		send_frame(make_frame(8'h00, 1'b0, 1'b0, 32'h0, 1'b0));
		for (i = 0; i < 8; i++)
			send_frame(make_frame(8'h01 << i, i[0], 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'hFF, 1'b1, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h18, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h07, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'hE0, 1'b1, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h03, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h00, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h00, 1'b1, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h81, 1'b0, 1'b0, 32'h0, 1'b1));
		send_frame(make_frame(8'h80, 1'b0, 1'b1, 32'h7FFF_FFF0, 1'b0));
		send_frame(make_frame(8'h80, 1'b1, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h01, 1'b0, 1'b1, 32'h8000_0000, 1'b0));
		send_frame(make_frame(8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0));
		send_frame(make_frame(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
		drain_steer();
	endtask

	// End flag: threshold zero sets it on every frame, a threshold above eight
	// can never be reached, and at eight only a full bar sets it. Clear and
	// restart both drop the sticky flag.
	task automatic test_end_threshold();
		set_config(16'd8, 16'd0, 16'd0, 16'd10000, 16'd0);
		send_frame(make_frame(8'h00, 1'b0, 1'b0, 32'h0, 1'b1));
		send_frame(make_frame(8'h10, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
		set_config(16'd8, 16'd0, 16'd0, 16'd10000, 16'd15);
		send_frame(make_frame(8'hFF, 1'b0, 1'b1, 32'h1234_5678, 1'b0));
		send_frame(make_frame(8'hFF, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
		set_config(16'd8, 16'd0, 16'd0, 16'd10000, 16'd8);
		send_frame(make_frame(8'h7F, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'hFF, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h08, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h08, 1'b0, 1'b0, 32'h0, 1'b1));
		send_frame(make_frame(8'hFF, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h08, 1'b0, 1'b1, 32'h0, 1'b0));
		drain_steer();
	endtask

	// Integral clamp: build a large negative sum, then lower the limit below it
	// so the next frame pulls the sum inside; a zero limit pins it to zero.
	task automatic test_integral_clamp();
		int i;
		set_config(16'd0, 16'd1, 16'd0, 16'd32767, 16'd9);
		send_frame(make_frame(8'h00, 1'b0, 1'b1, 32'h0, 1'b0));
		for (i = 0; i < 30; i++)
			send_frame(make_frame(8'h01, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
		set_config(16'd0, 16'd3, 16'd0, 16'd100, 16'd9);
		send_frame(make_frame(8'h18, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h80, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h00, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
		set_config(16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd9);
		send_frame(make_frame(8'h80, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h01, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
	endtask

	// Output saturation from each term at the extreme gains, with the error
	// swinging rail to rail so the derivative term is at its largest.
	task automatic test_gain_saturation();
		set_config(16'h7FFF, 16'd0, 16'd0, 16'd10000, 16'd7);
		send_frame(make_frame(8'h80, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h01, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
		set_config(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'd7);
		send_frame(make_frame(8'h80, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h01, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h00, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
		set_config(16'd0, 16'd0, 16'h7FFF, 16'd10000, 16'd7);
		send_frame(make_frame(8'h01, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h80, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h01, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h00, 1'b0, 1'b0, 32'h0, 1'b0));
		drain_steer();
	endtask

	// A write to an index past the register file must change nothing.
	task automatic test_spare_index();
		set_config(16'd5, 16'd2, 16'd3, 16'd500, 16'd6);
		cfg_put(CFG_SPARE_INDEX, 16'($urandom()));
		cfg_valid <= 1'b0;
		send_frame(make_frame(8'h0C, 1'b0, 1'b0, 32'h0, 1'b0));
		send_frame(make_frame(8'h3F, 1'b1, 1'b0, 32'h0, 1'b0));
		drain_steer();
	endtask

	// Back pressure: the receiver holds off for a long stretch while frames keep
	// coming back to back, so the result register fills and the input stalls.
	task automatic test_backpressure();
		int i;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (i = 0; i < 24; i++)
			send_frame(random_frame());
		drain_steer();
	endtask

	// Random frames over several settings. Phase 0 and 1 take the top and bottom
	// of every register; the rest are random. Idling cycles through none, light
	// and heavy so gaps land on every step of the core's work.
	task automatic test_random_frames();
		int ph;
		int i;
		int lim;
		int thr;
		for (ph = 0; ph < 9; ph++) begin
			if (ph == 0) begin
				set_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
			end else if (ph == 1) begin
				set_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFF0);
			end else begin
				lim = $urandom_range(0, 99) < 20 ? $urandom_range(0, 200) : $urandom();
				thr = ($urandom() & 32'hFFF0) | $urandom_range(0, 15);
				set_config(random_gain(), random_gain(), random_gain(), lim[15:0], thr[15:0]);
			end
			case (ph % 3)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 20;
					stall_pct = 20;
				end
				default: begin
					gap_pct = 60;
					stall_pct = 50;
				end
			endcase
			for (i = 0; i < 88; i++)
				send_frame(random_frame());
			drain_steer();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_end_threshold();
		test_integral_clamp();
		test_gain_saturation();
		test_spare_index();
		test_backpressure();
		test_random_frames();
		// Everything is in; give the core time to show any stray beat.
		while (pending_steer.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("line_follow_pid_steer_core regression: pass");
		else
			$display("line_follow_pid_steer_core regression: fail");
		$finish;
	end

endmodule
